@@ hdl/hcl_pkg.sv @@
// ----------------------------------------------------------------------------
// hcl_pkg
// shared types and constants of the hex command loader parser
// ----------------------------------------------------------------------------
package hcl_pkg;

    // memory geometry, held one bit wider than an address so that 65536 fits
    localparam logic [16:0] MEM_BYTES  = 17'd32768;
    localparam logic [16:0] DUMP_BYTES = 17'd256;
    localparam logic [16:0] ROW_BYTES  = 17'd16;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;

    // command characters
    localparam logic [7:0] CH_CLAIM    = 8'h21;  // !
    localparam logic [7:0] CH_RELEASE  = 8'h2e;  // .
    localparam logic [7:0] CH_ADDR     = 8'h40;  // @
    localparam logic [7:0] CH_DATA     = 8'h23;  // #
    localparam logic [7:0] CH_ECHO_ON  = 8'h2b;  // +
    localparam logic [7:0] CH_ECHO_OFF = 8'h2d;  // -
    localparam logic [7:0] CH_RESET    = 8'h72;  // r
    localparam logic [7:0] CH_ERASE    = 8'h73;  // s
    localparam logic [7:0] CH_DUMP     = 8'h3d;  // =
    localparam logic [7:0] CH_DIGEST   = 8'h6d;  // m
    localparam logic [7:0] CH_MEMTEST  = 8'h74;  // t
    localparam logic [7:0] CH_HELP     = 8'h3f;  // ?

    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_CLAIM   = 4'd1,
        ACT_RELEASE = 4'd2,
        ACT_DUMP    = 4'd3,
        ACT_ERASE   = 4'd4,
        ACT_RESET   = 4'd5,
        ACT_DIGEST  = 4'd6,
        ACT_HELP    = 4'd7,
        ACT_MEMTEST = 4'd8
    } action_t;

    // result beat, first member is the top bit
    typedef struct packed {
        logic        pad;
        logic        bus_owned;
        logic [15:0] dump_start;
        action_t     action;
        logic [7:0]  write_data;
        logic [15:0] write_addr;
        logic        write_valid;
        logic        echo;
    } result_t;

endpackage

@@ hdl/hex_command_loader_parser_core.sv @@
// ----------------------------------------------------------------------------
// hex_command_loader_parser_core
// decodes received characters into hex loads, byte writes and action codes
// ----------------------------------------------------------------------------
// Usage
//   s_tvalid/s_tready/s_tdata carry one received character per beat.
//   m_tvalid/m_tready/m_tdata return exactly one result beat per character,
//   in order: echo decision, byte write request, action code, dump start
//   address and the bus claimed flag after the character.
// Latency and throughput
//   a result appears in the cycle after its character is taken; one
//   character per cycle is accepted while the receiver takes results, set
//   by the single result register that the decode writes into.
// Stall
//   while the receiver holds m_tready low the result waits in the output
//   register and s_tready drops; a new character is taken in the same cycle
//   that the waiting result leaves.
// Reset
//   aresetn low clears address, data, nibble count, mode (data mode), bus
//   claim and echo off, and empties the output register.
// ----------------------------------------------------------------------------
module hex_command_loader_parser_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hcl_pkg::IN_DATA_W-1:0]  s_tdata,   // rx_char
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // echo, write_valid, write_addr[15:0], write_data[7:0], action[3:0],
    // dump_start[15:0], bus_owned, zero pad
    output logic [hcl_pkg::OUT_DATA_W-1:0] m_tdata
);
    import hcl_pkg::*;

    logic [15:0] address_reg, address_next;
    logic [7:0]  data_shift_reg, data_shift_next;
    logic        nibble_count_reg, nibble_count_next;
    logic        address_mode_reg, address_mode_next;
    logic        claimed_reg, claimed_next;
    logic        echo_off_reg, echo_off_next;
    logic        m_valid_reg;
    result_t     result_reg, result_next;

    logic        accept;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic        normal;
    logic [16:0] mem_left;
    logic [16:0] dump_lim;
    logic [16:0] dump_adv;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (s_tdata inside {[8'h30:8'h39]}) begin
            hex_val = s_tdata[3:0];
        end else if (s_tdata inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_val = s_tdata[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    // dump length: rows of 16 below memory size, capped at the dump size
    always_comb begin
        mem_left = ({1'b0, address_reg} < MEM_BYTES) ?
                   (MEM_BYTES - {1'b0, address_reg}) : 17'd0;
        dump_lim = (mem_left < DUMP_BYTES) ? mem_left : DUMP_BYTES;
        dump_adv = (dump_lim + (ROW_BYTES - 17'd1)) & ~(ROW_BYTES - 17'd1);
    end

    always_comb begin
        address_next      = address_reg;
        data_shift_next   = data_shift_reg;
        nibble_count_next = nibble_count_reg;
        address_mode_next = address_mode_reg;
        claimed_next      = claimed_reg;
        echo_off_next     = echo_off_reg;
        result_next       = '0;
        normal            = 1'b1;
        if (is_hex) begin
            if (address_mode_reg) begin
                address_next = {address_reg[11:0], hex_val};
            end else begin
                data_shift_next = {data_shift_reg[3:0], hex_val};
                if (nibble_count_reg) begin
                    if (claimed_reg) begin
                        result_next.write_valid = 1'b1;
                        result_next.write_addr  = address_reg;
                        result_next.write_data  = data_shift_next;
                    end
                    address_next      = address_reg + 16'd1;
                    nibble_count_next = 1'b0;
                end else begin
                    nibble_count_next = 1'b1;
                end
            end
        end else begin
            case (s_tdata)
                CH_CLAIM: begin
                    claimed_next       = 1'b1;
                    result_next.action = ACT_CLAIM;
                end
                CH_RELEASE: begin
                    claimed_next       = 1'b0;
                    result_next.action = ACT_RELEASE;
                end
                CH_ADDR: begin
                    address_mode_next = 1'b1;
                    nibble_count_next = 1'b0;
                end
                CH_DATA: begin
                    address_mode_next = 1'b0;
                    nibble_count_next = 1'b0;
                end
                CH_ECHO_ON:  echo_off_next = 1'b0;
                CH_ECHO_OFF: echo_off_next = 1'b1;
                CH_RESET:    result_next.action = ACT_RESET;
                CH_ERASE: begin
                    if (claimed_reg) begin
                        result_next.action = ACT_ERASE;
                    end else begin
                        normal = 1'b0;
                    end
                end
                CH_DUMP: begin
                    normal = 1'b0;
                    if (claimed_reg) begin
                        result_next.action     = ACT_DUMP;
                        result_next.dump_start = address_reg;
                        address_next           = address_reg + dump_adv[15:0];
                    end
                end
                CH_DIGEST: begin
                    normal = 1'b0;
                    if (claimed_reg) begin
                        result_next.action = ACT_DIGEST;
                    end
                end
                CH_MEMTEST: begin
                    normal = 1'b0;
                    if (claimed_reg) begin
                        result_next.action = ACT_MEMTEST;
                    end
                end
                CH_HELP: begin
                    normal             = 1'b0;
                    result_next.action = ACT_HELP;
                end
                default: normal = 1'b0;
            endcase
        end
        result_next.echo      = normal && !echo_off_next;
        result_next.bus_owned = claimed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg      <= '0;
            data_shift_reg   <= '0;
            nibble_count_reg <= 1'b0;
            address_mode_reg <= 1'b0;
            claimed_reg      <= 1'b0;
            echo_off_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                address_reg      <= address_next;
                data_shift_reg   <= data_shift_next;
                nibble_count_reg <= nibble_count_next;
                address_mode_reg <= address_mode_next;
                claimed_reg      <= claimed_next;
                echo_off_reg     <= echo_off_next;
                m_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTH
    // a write only goes out while the bus is claimed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.write_valid |-> result_reg.bus_owned)
        else $error("write issued without bus claim");

    // guarded actions need the bus
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (result_reg.action == ACT_DUMP ||
                        result_reg.action == ACT_ERASE ||
                        result_reg.action == ACT_DIGEST ||
                        result_reg.action == ACT_MEMTEST)
        |-> result_reg.bus_owned)
        else $error("guarded action without bus claim");

    // reported claim flag tracks the internal one
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) |-> result_reg.bus_owned == claimed_reg)
        else $error("bus_owned out of step with claim state");

    // a written data byte always advances the address
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && result_next.write_valid |=> address_reg == $past(address_reg) + 16'd1)
        else $error("address did not advance after a write");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hex command loader parser: a burst driver feeds
// received characters, a stalling sink takes the result beats, and a
// cycle-free decoder predicts echo, byte writes, action codes, dump start and
// bus ownership for each accepted character and checks every result beat
// ----------------------------------------------------------------------------
module tb;
    import hcl_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    hex_command_loader_parser_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    logic [7:0]  rx_feed [$];
    result_t     pending_results [$];
    int unsigned cyc = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          errors = 0;
    int          n_checked = 0;
    int          n_writes = 0;
    int          n_dumps = 0;
    int          n_actions = 0;

    // decoder state
    logic [15:0] ld_addr = '0;
    logic [7:0]  ld_data = '0;
    logic        ld_half = 1'b0;
    logic        addr_mode = 1'b0;
    logic        bus_claimed = 1'b0;
    logic        echo_muted = 1'b0;

    function automatic result_t decode_char(input logic [7:0] ch);
        result_t r;
        logic [3:0] nib;
        logic is_hex;
        logic shown;
        int adv;
        r = '0;
        nib = '0;
        is_hex = 1'b1;
        shown = 1'b0;
        if (ch >= "0" && ch <= "9") nib = 4'(ch - "0");
        else if (ch >= "a" && ch <= "f") nib = 4'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F") nib = 4'(ch - "A" + 8'd10);
        else is_hex = 1'b0;
        if (is_hex) begin
            shown = 1'b1;
            if (addr_mode) begin
                ld_addr = {ld_addr[11:0], nib};
            end else begin
                ld_data = {ld_data[3:0], nib};
                if (ld_half) begin
                    if (bus_claimed) begin
                        r.write_valid = 1'b1;
                        r.write_addr = ld_addr;
                        r.write_data = ld_data;
                    end
                    ld_addr = ld_addr + 16'd1;
                    ld_half = 1'b0;
                end else begin
                    ld_half = 1'b1;
                end
            end
        end else begin
            case (ch)
                CH_CLAIM: begin
                    bus_claimed = 1'b1;
                    r.action = ACT_CLAIM;
                    shown = 1'b1;
                end
                CH_RELEASE: begin
                    bus_claimed = 1'b0;
                    r.action = ACT_RELEASE;
                    shown = 1'b1;
                end
                CH_ADDR: begin
                    addr_mode = 1'b1;
                    ld_half = 1'b0;
                    shown = 1'b1;
                end
                CH_DATA: begin
                    addr_mode = 1'b0;
                    ld_half = 1'b0;
                    shown = 1'b1;
                end
                CH_ECHO_ON: begin
                    echo_muted = 1'b0;
                    shown = 1'b1;
                end
                CH_ECHO_OFF: begin
                    echo_muted = 1'b1;
                    shown = 1'b1;
                end
                CH_RESET: begin
                    r.action = ACT_RESET;
                    shown = 1'b1;
                end
                CH_ERASE: begin
                    if (bus_claimed) begin
                        r.action = ACT_ERASE;
                        shown = 1'b1;
                    end
                end
                CH_DUMP: begin
                    if (bus_claimed) begin
                        r.action = ACT_DUMP;
                        r.dump_start = ld_addr;
                        // whole rows below the end of memory, capped at one dump
                        adv = 0;
                        while (adv < int'(DUMP_BYTES) && adv + int'(ld_addr) < int'(MEM_BYTES))
                            adv += int'(ROW_BYTES);
                        ld_addr = ld_addr + adv[15:0];
                    end
                end
                CH_DIGEST: begin
                    if (bus_claimed) r.action = ACT_DIGEST;
                end
                CH_MEMTEST: begin
                    if (bus_claimed) r.action = ACT_MEMTEST;
                end
                CH_HELP: begin
                    r.action = ACT_HELP;
                end
                default: ;
            endcase
        end
        r.echo = shown & ~echo_muted;
        r.bus_owned = bus_claimed;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 8'd10);
    endfunction

    task automatic put_hex(input logic [15:0] val, input int ndig);
        for (int i = ndig - 1; i >= 0; i--) rx_feed.push_back(hex_char(val[4*i +: 4]));
    endtask

    task automatic flag_mismatch(input string msg);
        if (errors < 30) $display("error at result %0d: %s", n_checked, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // sender: bursts of beats separated by random gaps, calm stretches included
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (rx_feed.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_feed.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = (cyc[10:9] == 2'b01) ? 0 : $urandom_range(0, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink: random stalls, switched off in its own calm stretches
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (cyc[10:9] != 2'b10 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 9);
        end
    end

    // accepted input beats feed the decoder, result beats are checked in order
    always @(posedge aclk) begin : mon
        result_t got;
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) pending_results.push_back(decode_char(s_tdata));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (pending_results.size() == 0) begin
                    flag_mismatch("result beat with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    check_field("echo", 16'(got.echo), 16'(want.echo));
                    check_field("write_valid", 16'(got.write_valid), 16'(want.write_valid));
                    check_field("write_addr", got.write_addr, want.write_addr);
                    check_field("write_data", 16'(got.write_data), 16'(want.write_data));
                    check_field("action", 16'(got.action), 16'(want.action));
                    check_field("dump_start", got.dump_start, want.dump_start);
                    check_field("bus_owned", 16'(got.bus_owned), 16'(want.bus_owned));
                    n_checked++;
                    if (want.write_valid) n_writes++;
                    if (want.action == ACT_DUMP) n_dumps++;
                    else if (want.action != ACT_NONE) n_actions++;
                end
            end
        end
    end

    initial begin : stim
        logic [7:0] cmd_chars [6];
        logic [15:0] val;
        int base;
        int noise_n;
        int pick;
        int len;
        cmd_chars = '{CH_DUMP, CH_ERASE, CH_DIGEST, CH_MEMTEST, CH_RESET, CH_HELP};
        // guarded commands unclaimed, then claimed with a dump at the top of memory
        rx_feed = '{CH_HELP, CH_ERASE, CH_DUMP, CH_DIGEST, CH_MEMTEST, CH_RESET,
                    CH_CLAIM, CH_ADDR, "7", "F", "f", "8", CH_DUMP, CH_DUMP,
                    CH_DATA, "0", "9", CH_ECHO_OFF, "A", "a", CH_ERASE, CH_DIGEST,
                    CH_MEMTEST, CH_ECHO_ON, CH_RELEASE, 8'h00, 8'hff, 8'h80};
        base = rx_feed.size();
        noise_n = 0;
        while (rx_feed.size() - base - noise_n < 1150) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                rx_feed.push_back(CH_ADDR);
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 4))
                        0: val = 16'h0000;
                        1: val = 16'hffff;
                        2: val = {12'h7ff, 4'($urandom)};
                        3: val = 16'h8000;
                        default: val = {8'h7f, 8'($urandom)};
                    endcase
                    put_hex(val, 4);
                end else begin
                    len = $urandom_range(1, 5);
                    for (int j = 0; j < len; j++) rx_feed.push_back(hex_char(4'($urandom)));
                end
                if ($urandom_range(0, 7) != 0) rx_feed.push_back(CH_DATA);
            end else if (pick < 65) begin
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++) rx_feed.push_back(hex_char(4'($urandom)));
            end else if (pick < 73) begin
                rx_feed.push_back(CH_CLAIM);
            end else if (pick < 77) begin
                rx_feed.push_back(CH_RELEASE);
            end else if (pick < 87) begin
                rx_feed.push_back(cmd_chars[$urandom_range(0, 5)]);
            end else if (pick < 92) begin
                rx_feed.push_back($urandom_range(0, 2) ? CH_ECHO_ON : CH_ECHO_OFF);
            end else begin
                len = $urandom_range(1, 3);
                for (int j = 0; j < len; j++) rx_feed.push_back(8'($urandom_range(0, 255)));
                noise_n += len;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (rx_feed.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (4) @(negedge aclk);

        $display("%0d characters checked: %0d byte writes, %0d dumps, %0d other actions",
                 n_checked, n_writes, n_dumps, n_actions);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule

@@ hex_command_loader_parser_core.f @@
hdl/hcl_pkg.sv
hdl/hex_command_loader_parser_core.sv
bench/tb.sv
